### rtl/banded_diagonal_match_mask_macros.svh
// Assertion macros for the banded diagonal match mask block.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef BANDED_DIAGONAL_MATCH_MASK_MACROS_SVH
`define BANDED_DIAGONAL_MATCH_MASK_MACROS_SVH

// Same-cycle implication.
`define BDM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define BDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/bdm_pkg.sv
// Shared types and constants for the banded diagonal match mask block.
// No dependencies; used by bdm_cell and banded_diagonal_match_mask.
package bdm_pkg;

    localparam int MAX_DIAG_DEF    = 64;
    localparam int SCORE_WIDTH_DEF = 16;

    localparam int COST_W  = 16;
    localparam int ROW_W   = 15;
    localparam int COUNT_W = 16;
    localparam int USED_W  = 7;
    localparam int MASK_W  = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SCORE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_SCORE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LENGTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAGONALS_USED = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [1:0] base;
    } t_tap;

    typedef struct packed {
        logic                     accept;
        logic                     clear;
        logic [1:0]               second_base;
        logic                     second_valid;
        logic [COUNT_W-1:0]       item_count;
        logic [USED_W-1:0]        used;
        logic signed [COST_W-1:0] match_score;
        logic signed [COST_W-1:0] mismatch_score;
        logic [ROW_W-1:0]         keep_length;
    } t_cell_ctrl;

endpackage

### rtl/bdm_cell.sv
// One diagonal cell: delay tap, running score, run start and best run.
// Depends on bdm_pkg; instantiated once per diagonal 1 to MAX_DIAG-1 by the top level.
module bdm_cell #(
    parameter int DIAG        = 1,
    parameter int SCORE_WIDTH = bdm_pkg::SCORE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdm_pkg::t_cell_ctrl i_ctrl,
    input  bdm_pkg::t_tap       i_tap,
    output bdm_pkg::t_tap       o_tap,
    output logic                o_keep
);
    import bdm_pkg::*;

    localparam int SUM_W = ((SCORE_WIDTH > COST_W) ? SCORE_WIDTH : COST_W) + 2;
    localparam int SC_W  = SCORE_WIDTH - 1;
    localparam logic [SC_W-1:0] SMAX = '1;

    t_tap             r_tap, n_tap;
    logic [SC_W-1:0]  r_score, n_score;
    logic [ROW_W-1:0] r_start, n_start;
    logic [ROW_W-1:0] r_best, n_best;

    logic                     w_en;
    logic                     w_hit;
    logic signed [COST_W-1:0] w_cost;
    logic signed [SUM_W-1:0]  w_sum;
    logic [COUNT_W-1:0]       w_row_full;
    logic [ROW_W-1:0]         w_row;
    logic [ROW_W-1:0]         w_start_eff;
    logic [ROW_W:0]           w_run_full;
    logic [ROW_W-1:0]         w_run;

    assign w_en   = USED_W'(DIAG) < i_ctrl.used;
    assign w_hit  = i_ctrl.accept && w_en && r_tap.valid && i_ctrl.second_valid &&
                    (i_ctrl.item_count >= COUNT_W'(DIAG));
    assign w_cost = (r_tap.base == i_ctrl.second_base) ? i_ctrl.match_score
                                                        : i_ctrl.mismatch_score;
    assign w_sum  = SUM_W'({1'b0, r_score}) + SUM_W'(w_cost);

    assign w_row_full  = i_ctrl.item_count - COUNT_W'(DIAG);
    assign w_row       = (w_row_full > COUNT_W'(ROW_MAX)) ? ROW_MAX : w_row_full[ROW_W-1:0];
    assign w_start_eff = (r_start == '0) ? w_row : r_start;
    assign w_run_full  = (w_row >= w_start_eff) ?
                         ({1'b0, w_row} - {1'b0, w_start_eff} + (ROW_W+1)'(1)) : '0;
    assign w_run       = w_run_full[ROW_W] ? ROW_MAX : w_run_full[ROW_W-1:0];

    always_comb begin
        n_tap   = r_tap;
        n_score = r_score;
        n_start = r_start;
        n_best  = r_best;
        if (i_ctrl.accept) begin
            n_tap = i_tap;
        end
        if (w_hit) begin
            if (w_sum <= 0) begin
                n_score = '0;
                n_start = '0;
            end else begin
                n_score = (w_sum > SUM_W'({1'b0, SMAX})) ? SMAX : w_sum[SC_W-1:0];
                n_start = w_start_eff;
                if (w_run > r_best) begin
                    n_best = w_run;
                end
            end
        end
        o_keep = w_en && (n_best >= i_ctrl.keep_length);
        if (i_ctrl.clear) begin
            n_tap   = '0;
            n_score = '0;
            n_start = '0;
            n_best  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap   <= '0;
            r_score <= '0;
            r_start <= '0;
            r_best  <= '0;
        end else begin
            r_tap   <= n_tap;
            r_score <= n_score;
            r_start <= n_start;
            r_best  <= n_best;
        end
    end

    assign o_tap = r_tap;

endmodule

### rtl/banded_diagonal_match_mask.sv
// Banded diagonal match mask. One item is taken per clock: every accepted item
// is scored in the cycle it is accepted by a chain of MAX_DIAG-1 cells, one per
// diagonal, with the first-sequence bases shifting one cell per item. The mask
// is registered and shown in the cycle after the item marked last; the input
// stalls only while a mask waits and the output is stalled.
// Depends on bdm_pkg, bdm_cell and banded_diagonal_match_mask_macros.svh.
`include "banded_diagonal_match_mask_macros.svh"

module banded_diagonal_match_mask #(
    parameter int MAX_DIAG    = bdm_pkg::MAX_DIAG_DEF,
    parameter int SCORE_WIDTH = bdm_pkg::SCORE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_first_base,
    input  logic                            i_first_valid,
    input  logic [1:0]                      i_second_base,
    input  logic                            i_second_valid,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bdm_pkg::MASK_W-1:0]      o_keep_mask,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bdm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bdm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bdm_pkg::*;

    logic signed [COST_W-1:0] r_match, r_mismatch;
    logic [ROW_W-1:0]         r_keep_len;
    logic [USED_W-1:0]        r_diag_used;
    logic [COUNT_W-1:0]       r_item_count, n_item_count;
    logic                     r_out_valid;
    logic [MASK_W-1:0]        r_mask;

    logic              w_in_acc;
    logic [USED_W-1:0] w_used;
    t_cell_ctrl        w_ctrl;
    t_tap              w_chain [1:MAX_DIAG-1];
    logic [MASK_W-1:0] w_keep;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign w_in_acc    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= 16'sd1;
            r_mismatch  <= -16'sd1;
            r_keep_len  <= 15'd11;
            r_diag_used <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MATCH_SCORE:    r_match     <= i_cfg_data;
                CFG_MISMATCH_SCORE: r_mismatch  <= i_cfg_data;
                CFG_KEEP_LENGTH:    r_keep_len  <= i_cfg_data[ROW_W-1:0];
                CFG_DIAGONALS_USED: r_diag_used <= i_cfg_data[USED_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_used = (r_diag_used > USED_W'(MAX_DIAG)) ? USED_W'(MAX_DIAG) : r_diag_used;

    always_comb begin
        w_ctrl.accept         = w_in_acc;
        w_ctrl.clear          = w_in_acc && i_last;
        w_ctrl.second_base    = i_second_base;
        w_ctrl.second_valid   = i_second_valid;
        w_ctrl.item_count     = r_item_count;
        w_ctrl.used           = w_used;
        w_ctrl.match_score    = r_match;
        w_ctrl.mismatch_score = r_mismatch;
        w_ctrl.keep_length    = r_keep_len;
    end

    assign w_chain[1] = '{valid: i_first_valid, base: i_first_base};

    genvar d;
    generate
        for (d = 0; d < MASK_W; d++) begin : g_diag
            if (d == 0 || d >= MAX_DIAG) begin : g_off
                assign w_keep[d] = 1'b0;
            end else if (d < MAX_DIAG - 1) begin : g_mid
                bdm_cell #(.DIAG(d), .SCORE_WIDTH(SCORE_WIDTH)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl),
                    .i_tap   (w_chain[d]),
                    .o_tap   (w_chain[d+1]),
                    .o_keep  (w_keep[d])
                );
            end else begin : g_end
                bdm_cell #(.DIAG(d), .SCORE_WIDTH(SCORE_WIDTH)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl),
                    .i_tap   (w_chain[d]),
                    .o_tap   (),
                    .o_keep  (w_keep[d])
                );
            end
        end
    endgenerate

    always_comb begin
        n_item_count = r_item_count;
        if (w_in_acc) begin
            if (i_last) begin
                n_item_count = '0;
            end else if (r_item_count != '1) begin
                n_item_count = r_item_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_item_count <= n_item_count;
            if (w_in_acc && i_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_last) begin
            r_mask <= w_keep;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_keep_mask = r_mask;

    `BDM_ASSERT_NEXT(a_mask_after_last, w_in_acc && i_last, o_valid)
    `BDM_ASSERT_NEXT(a_count_cleared, w_in_acc && i_last, r_item_count == '0)
    `BDM_ASSERT_SAME(a_bit0_clear, o_valid, !o_keep_mask[0])

endmodule
